>>> rtl/skt_pkg.sv
package skt_pkg;

    localparam int DEPTH   = 16;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int SCORE_W = 16;
    localparam int ENTRY_W = KEY_W + SCORE_W;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_DELETED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;
    localparam logic [2:0] ST_DUMP      = 3'd5;

    // One table entry as it sits in the memory, key in the upper bits.
    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [SCORE_W-1:0]      score;
    } entry_t;

    // Access request from the sequencer to the entry memory.
    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    // One result item handed to the output register.
    typedef struct packed {
        logic [2:0]              status;
        logic signed [KEY_W-1:0] key;
        logic [SCORE_W-1:0]      score;
        logic                    last;
    } result_t;

endpackage

>>> rtl/skt_ram.sv
module skt_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/skt_ctrl.sv
module skt_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               in_opcode,
    input  logic signed [skt_pkg::KEY_W-1:0] in_key,
    input  logic [skt_pkg::SCORE_W-1:0]      in_score,
    output skt_pkg::mem_req_t        mem_req,
    input  skt_pkg::entry_t          mem_rd_data,
    input  logic                     out_free,
    output logic                     res_push,
    output skt_pkg::result_t         res
);

    import skt_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE      = 9'b000000001,
        S_FIND_RD   = 9'b000000010,
        S_FIND_CMP  = 9'b000000100,
        S_SHIFT_RD  = 9'b000001000,
        S_SHIFT_WR  = 9'b000010000,
        S_PUT       = 9'b000100000,
        S_DUMP_RD   = 9'b001000000,
        S_DUMP_EMIT = 9'b010000000,
        S_REPORT    = 9'b100000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [1:0]              op_reg, op_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic [SCORE_W-1:0]      score_reg, score_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [2:0]              stat_reg, stat_next;

    logic [CNT_W-1:0] idx_ext;
    logic [CNT_W-1:0] idx_inc;
    logic             at_end;
    logic             ins_hit;
    logic             del_hit;

    assign idx_ext = CNT_W'(idx_reg);
    assign idx_inc = idx_ext + CNT_W'(1);
    assign at_end  = (idx_inc == cnt_reg);
    // The head is passed only by a strictly smaller key; later entries by
    // any key that is not smaller than the new one.
    assign ins_hit = (idx_reg == '0) ? (key_reg < mem_rd_data.key)
                                     : !(mem_rd_data.key < key_reg);
    assign del_hit = (mem_rd_data.key == key_reg);

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        key_next   = key_reg;
        score_next = score_reg;
        idx_next   = idx_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        stat_next  = stat_reg;
        mem_req    = '0;
        res_push   = 1'b0;
        res        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_opcode;
                    key_next   = in_key;
                    score_next = in_score;
                    idx_next   = '0;
                    case (in_opcode)
                        OP_INSERT:
                        begin
                            if (cnt_reg == CNT_W'(DEPTH))
                            begin
                                stat_next  = ST_FULL;
                                state_next = S_REPORT;
                            end
                            else if (cnt_reg == '0)
                            begin
                                pos_next   = '0;
                                state_next = S_PUT;
                            end
                            else
                            begin
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                state_next = S_FIND_RD;
                            end
                        end
                        OP_DUMP:
                        begin
                            if (cnt_reg == '0)
                            begin
                                stat_next  = ST_EMPTY;
                                state_next = S_REPORT;
                            end
                            else
                            begin
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_FIND_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = S_FIND_CMP;
            end

            S_FIND_CMP:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (ins_hit || at_end)
                    begin
                        pos_next = ins_hit ? idx_reg : idx_inc[IDX_W-1:0];
                        if (!ins_hit)
                        begin
                            // Goes to the tail, nothing to move.
                            state_next = S_PUT;
                        end
                        else
                        begin
                            idx_next   = cnt_reg[IDX_W-1:0];
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FIND_RD;
                    end
                end
                else
                begin
                    if (del_hit)
                    begin
                        if (at_end)
                        begin
                            cnt_next   = cnt_reg - CNT_W'(1);
                            stat_next  = ST_DELETED;
                            state_next = S_REPORT;
                        end
                        else
                        begin
                            state_next = S_SHIFT_RD;
                        end
                    end
                    else if (at_end)
                    begin
                        stat_next  = ST_NOT_FOUND;
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FIND_RD;
                    end
                end
            end

            S_SHIFT_RD:
            begin
                // An insert moves entries up from the tail, a delete moves
                // them down toward the freed slot.
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = (op_reg == OP_INSERT) ? idx_reg - IDX_W'(1)
                                                        : idx_reg + IDX_W'(1);
                state_next      = S_SHIFT_WR;
            end

            S_SHIFT_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_reg;
                mem_req.wr_data = mem_rd_data;
                if (op_reg == OP_INSERT)
                begin
                    if (idx_reg - IDX_W'(1) == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    if (idx_ext + CNT_W'(2) == cnt_reg)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        stat_next  = ST_DELETED;
                        state_next = S_REPORT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_SHIFT_RD;
                    end
                end
            end

            S_PUT:
            begin
                mem_req.wr_en         = 1'b1;
                mem_req.wr_addr       = pos_reg;
                mem_req.wr_data.key   = key_reg;
                mem_req.wr_data.score = score_reg;
                cnt_next              = cnt_reg + CNT_W'(1);
                stat_next             = ST_INSERTED;
                state_next            = S_REPORT;
            end

            S_DUMP_RD:
            begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_reg;
                state_next      = S_DUMP_EMIT;
            end

            S_DUMP_EMIT:
            begin
                if (out_free)
                begin
                    res_push   = 1'b1;
                    res.status = ST_DUMP;
                    res.key    = mem_rd_data.key;
                    res.score  = mem_rd_data.score;
                    res.last   = at_end;
                    if (at_end)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end

            S_REPORT:
            begin
                if (out_free)
                begin
                    res_push   = 1'b1;
                    res.status = stat_reg;
                    res.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        key_reg   <= key_next;
        score_reg <= score_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        stat_reg  <= stat_next;
    end

endmodule

>>> rtl/sorted_key_table.sv
// Sorted key table: up to 16 (key, score) records kept in ascending key order.
// An insert scans for its slot and moves the later entries up; a delete scans for the
// key and moves the later entries down. An insert into a full table, or a delete or
// dump on an empty one, is reported without a scan. A dump emits each record in table
// order, the last marked with m_tlast. One item is worked at a time; each moved entry
// is read, then written back, so the sequencer sets the rate. Reset (rst_n low,
// asynchronous) empties the table and drops any pending result.
module sorted_key_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // key[31:0], score[47:32]
    input  logic [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_key[31:0], out_score[47:32]
    output logic [2:0]  m_tuser,   // status[2:0]
    output logic        m_tlast
);

    import skt_pkg::*;

    mem_req_t mem_req;
    entry_t   mem_rd_data;
    logic     out_free;
    logic     res_push;
    result_t  res;

    logic                    m_tvalid_reg;
    logic signed [KEY_W-1:0] out_key_reg;
    logic [SCORE_W-1:0]      out_score_reg;
    logic [2:0]              status_reg;
    logic                    last_reg;

    // The entry memory holds the records in table order; slot 0 is the head.
    skt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data)
    );

    // The sequencer scans for the slot, moves entries one at a time through
    // the memory and produces the result items.
    skt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_opcode   (s_tuser),
        .in_key      (s_tdata[31:0]),
        .in_score    (s_tdata[47:32]),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data),
        .out_free    (out_free),
        .res_push    (res_push),
        .res         (res)
    );

    // Output register: a result waits here while the sequencer goes on.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_push)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            status_reg    <= res.status;
            out_key_reg   <= res.key;
            out_score_reg <= res.score;
            last_reg      <= res.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {out_score_reg, out_key_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

endmodule
